[rtl/core/shpm_pkg.sv]
// ----------------------------------------------------------------------------
// shpm_pkg: shared types and constants
// Command codes, item and result structs, sequencer states and the hash
// multiplier for the substring hash prefix match unit.
// ----------------------------------------------------------------------------
package shpm_pkg;

  localparam int POS_W  = 13;
  localparam int HASH_W = 64;
  localparam int CHAR_W = 8;

  localparam logic [HASH_W-1:0] HASH_MUL = 64'd1000000007;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_HASH   = 2'd2,
    CMD_MATCH  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [CHAR_W-1:0] char_value;
    logic [POS_W-1:0]  left_pos;
    logic [POS_W-1:0]  right_pos;
  } cmd_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic [POS_W-1:0]  match_length;
    logic              error_flag;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_RD,
    S_APP_PM,
    S_APP_PW,
    S_APP_WR,
    S_H_RD1,
    S_H_RD2,
    S_H_MUL,
    S_H_WAIT,
    S_M_RD0,
    S_M_BASE,
    S_M_CHK,
    S_M_RD1,
    S_M_RD2,
    S_M_MUL,
    S_M_WAIT
  } state_e;

endpackage

[rtl/core/substring_hash_prefix_match_unit.sv]
// ----------------------------------------------------------------------------
// substring_hash_prefix_match_unit: polynomial hash text store and queries
// Keeps prefix hashes and multiplier powers in two RAMs; answers substring
// hash and longest-prefix-match queries with one shared multiplier.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// its result has been issued, and the result appears on res_o for exactly one
// cycle with res_valid_o high. Every 64-bit product goes through one shared
// 32x32 multiplier: clear, an append to a full store and a bad position are
// answered straight from idle; an append needs two products, a substring
// hash one, and a prefix match one per search probe, with at most
// floor(log2(text_length - left_pos + 1)) + 1 probes.
// There is no way to hold a result off, so it must be taken when strobed.
module substring_hash_prefix_match_unit #(
  parameter int MAX_LEN = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  shpm_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  output shpm_pkg::res_t res_o
);

  localparam int AW = $clog2(MAX_LEN + 1);
  localparam int IW = (AW > shpm_pkg::POS_W) ? AW : shpm_pkg::POS_W;
  localparam int SW = IW + 1;
  localparam int HW = shpm_pkg::HASH_W;

  shpm_pkg::state_e state_q, state_d;

  logic [AW-1:0] len_q, len_d;
  logic          res_valid_q, res_fire;
  shpm_pkg::res_t res_q, res_d;

  logic [SW-1:0] start_q, r_q, lo_q, hi_q, mid_q, best_q, mid_d;
  logic [SW:0]   mid_sum;
  logic [SW-1:0] l_ext, r_ext, len_ext;
  logic [shpm_pkg::CHAR_W-1:0] byte_q;
  logic [HW-1:0] base_q, ref_q, op_a_q, op_b_q;

  logic          accept, full, err_hash, err_match;
  logic [AW-1:0] p_raddr, w_raddr, waddr;
  logic [HW-1:0] p_rdata, w_rdata, p_rd, w_rd, p_wdata, w_wdata;
  logic          we, pz_q, wz_q;
  logic          mul_start, mul_done;
  logic [HW-1:0] mul_a, mul_b, mul_prod;

  assign accept    = start && !busy;
  assign l_ext     = SW'(cmd_i.left_pos);
  assign r_ext     = SW'(cmd_i.right_pos);
  assign len_ext   = SW'(len_q);
  assign full      = (len_q == AW'(MAX_LEN));
  assign err_hash  = (l_ext == '0) || (l_ext > r_ext) || (r_ext > len_ext);
  assign err_match = (l_ext == '0) || (l_ext > len_ext);
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_d     = mid_sum[SW:1];
  assign waddr     = AW'(len_q + AW'(1));
  assign p_wdata   = base_q;
  assign w_wdata   = mul_prod;
  assign p_rd      = pz_q ? '0 : p_rdata;
  assign w_rd      = wz_q ? HW'(1) : w_rdata;

  shpm_ram #(.WIDTH(HW), .DEPTH(MAX_LEN + 1)) u_prefix_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(p_wdata),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  shpm_ram #(.WIDTH(HW), .DEPTH(MAX_LEN + 1)) u_power_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(w_wdata),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  shpm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      shpm_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            shpm_pkg::CMD_APPEND: state_d = full ? shpm_pkg::S_IDLE : shpm_pkg::S_APP_RD;
            shpm_pkg::CMD_HASH:   state_d = err_hash ? shpm_pkg::S_IDLE : shpm_pkg::S_H_RD1;
            shpm_pkg::CMD_MATCH:  state_d = err_match ? shpm_pkg::S_IDLE : shpm_pkg::S_M_RD0;
            default:              state_d = shpm_pkg::S_IDLE;
          endcase
        end
      end
      shpm_pkg::S_APP_RD: state_d = shpm_pkg::S_APP_PM;
      shpm_pkg::S_APP_PM: state_d = shpm_pkg::S_APP_PW;
      shpm_pkg::S_APP_PW: if (mul_done) state_d = shpm_pkg::S_APP_WR;
      shpm_pkg::S_APP_WR: if (mul_done) state_d = shpm_pkg::S_IDLE;
      shpm_pkg::S_H_RD1:  state_d = shpm_pkg::S_H_RD2;
      shpm_pkg::S_H_RD2:  state_d = shpm_pkg::S_H_MUL;
      shpm_pkg::S_H_MUL:  state_d = shpm_pkg::S_H_WAIT;
      shpm_pkg::S_H_WAIT: if (mul_done) state_d = shpm_pkg::S_IDLE;
      shpm_pkg::S_M_RD0:  state_d = shpm_pkg::S_M_BASE;
      shpm_pkg::S_M_BASE: state_d = shpm_pkg::S_M_CHK;
      shpm_pkg::S_M_CHK:  state_d = (lo_q <= hi_q) ? shpm_pkg::S_M_RD1 : shpm_pkg::S_IDLE;
      shpm_pkg::S_M_RD1:  state_d = shpm_pkg::S_M_RD2;
      shpm_pkg::S_M_RD2:  state_d = shpm_pkg::S_M_MUL;
      shpm_pkg::S_M_MUL:  state_d = shpm_pkg::S_M_WAIT;
      shpm_pkg::S_M_WAIT: if (mul_done) state_d = shpm_pkg::S_M_CHK;
      default:            state_d = shpm_pkg::S_IDLE;
    endcase
  end

  // memory and multiplier control
  always_comb begin
    p_raddr   = '0;
    w_raddr   = '0;
    we        = 1'b0;
    mul_start = 1'b0;
    mul_a     = base_q;
    mul_b     = op_b_q;
    case (state_q)
      shpm_pkg::S_APP_RD: begin
        p_raddr = len_q;
        w_raddr = len_q;
      end
      shpm_pkg::S_APP_PM: begin
        mul_start = 1'b1;
        mul_a     = p_rd;
        mul_b     = shpm_pkg::HASH_MUL;
      end
      shpm_pkg::S_APP_PW: begin
        mul_start = mul_done;
        mul_a     = ref_q;
        mul_b     = shpm_pkg::HASH_MUL;
      end
      shpm_pkg::S_APP_WR: we = mul_done;
      shpm_pkg::S_H_RD1: begin
        p_raddr = AW'(start_q - SW'(1));
        w_raddr = AW'(r_q - start_q + SW'(1));
      end
      shpm_pkg::S_H_RD2: p_raddr = AW'(r_q);
      shpm_pkg::S_H_MUL: mul_start = 1'b1;
      shpm_pkg::S_M_RD0: p_raddr = AW'(start_q - SW'(1));
      shpm_pkg::S_M_RD1: begin
        p_raddr = AW'(mid_q);
        w_raddr = AW'(mid_q);
      end
      shpm_pkg::S_M_RD2: p_raddr = AW'(start_q + mid_q - SW'(1));
      shpm_pkg::S_M_MUL: mul_start = 1'b1;
      default: ;
    endcase
  end

  // result and length
  always_comb begin
    res_fire = 1'b0;
    res_d    = '0;
    len_d    = len_q;
    case (state_q)
      shpm_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            shpm_pkg::CMD_CLEAR: begin
              res_fire = 1'b1;
              len_d    = '0;
            end
            shpm_pkg::CMD_APPEND: begin
              res_fire         = full;
              res_d.error_flag = full;
            end
            shpm_pkg::CMD_HASH: begin
              res_fire         = err_hash;
              res_d.error_flag = err_hash;
            end
            shpm_pkg::CMD_MATCH: begin
              res_fire         = err_match;
              res_d.error_flag = err_match;
            end
            default: ;
          endcase
        end
      end
      shpm_pkg::S_APP_WR: begin
        if (mul_done) begin
          res_fire = 1'b1;
          len_d    = waddr;
        end
      end
      shpm_pkg::S_H_WAIT: begin
        res_fire         = mul_done;
        res_d.hash_value = ref_q - mul_prod;
      end
      shpm_pkg::S_M_CHK: begin
        res_fire           = (lo_q > hi_q);
        res_d.match_length = best_q[shpm_pkg::POS_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shpm_pkg::S_IDLE;
      len_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      res_valid_q <= res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    pz_q <= (p_raddr == '0);
    wz_q <= (w_raddr == '0);
    if (res_fire) begin
      res_q <= res_d;
    end
    case (state_q)
      shpm_pkg::S_IDLE: begin
        if (accept) begin
          start_q <= l_ext;
          r_q     <= r_ext;
          byte_q  <= cmd_i.char_value;
          lo_q    <= SW'(1);
          hi_q    <= len_ext - l_ext + SW'(1);
          best_q  <= '0;
        end
      end
      shpm_pkg::S_APP_PM: ref_q <= w_rd;
      shpm_pkg::S_APP_PW: begin
        if (mul_done) begin
          base_q <= mul_prod + HW'(byte_q);
        end
      end
      shpm_pkg::S_H_RD2: begin
        base_q <= p_rd;
        op_b_q <= w_rd;
      end
      shpm_pkg::S_H_MUL:  ref_q  <= p_rd;
      shpm_pkg::S_M_BASE: base_q <= p_rd;
      shpm_pkg::S_M_CHK:  mid_q  <= mid_d;
      shpm_pkg::S_M_RD2: begin
        ref_q  <= p_rd;
        op_b_q <= w_rd;
      end
      shpm_pkg::S_M_MUL: op_a_q <= p_rd;
      shpm_pkg::S_M_WAIT: begin
        if (mul_done) begin
          if (op_a_q - mul_prod == ref_q) begin
            best_q <= mid_q;
            lo_q   <= mid_q + SW'(1);
          end else begin
            hi_q <= mid_q - SW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign busy        = (state_q != shpm_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> !busy)
    else $error("result issued while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= AW'(MAX_LEN))
    else $error("text length beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == shpm_pkg::S_APP_PW || state_q == shpm_pkg::S_APP_WR ||
                  state_q == shpm_pkg::S_H_WAIT || state_q == shpm_pkg::S_M_WAIT))
    else $error("product returned outside a wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.error_flag |-> res_o.hash_value == '0 && res_o.match_length == '0)
    else $error("error result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shpm_pkg::S_M_CHK |-> lo_q != '0 && best_q < lo_q)
    else $error("search bounds inconsistent");

endmodule

[rtl/core/shpm_ram.sv]
// ----------------------------------------------------------------------------
// shpm_ram: generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module shpm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4097
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/shpm_mul.sv]
// ----------------------------------------------------------------------------
// shpm_mul: multi-cycle 64x64 multiplier, low 64 bits
// One 32x32 multiplier, three partial products accumulated in turn.
// ----------------------------------------------------------------------------
module shpm_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [shpm_pkg::HASH_W-1:0]   a_i,
  input  logic [shpm_pkg::HASH_W-1:0]   b_i,
  output logic                          done_o,
  output logic [shpm_pkg::HASH_W-1:0]   prod_o
);

  logic [63:0] a_q, b_q, acc_q, acc_d, prod_q, mul_full;
  logic [31:0] m_x, m_y;
  logic [1:0]  cnt_q;
  logic        run_q, done_q;

  always_comb begin
    m_x = (cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    m_y = (cnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];
    mul_full = m_x * m_y;
    acc_d = (cnt_q == 2'd1) ? prod_q : acc_q + {prod_q[31:0], 32'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 2'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (run_q) begin
      prod_q <= mul_full;
      if (cnt_q != 2'd0) begin
        acc_q <= acc_d;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !run_q)
    else $error("multiplier restarted while running");

endmodule

[test/substring_hash_prefix_match_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_hash_prefix_match_unit_tb: self-checking testbench
// Sends clear, append, substring hash and prefix match items through the
// start/busy handshake. A behavioral copy of the prefix hash and power tables
// predicts each answer, and every strobed result is compared in order.
// ----------------------------------------------------------------------------
module substring_hash_prefix_match_unit_tb;

  localparam int TEXT_CAP      = 4096;
  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 10;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_REPORTS   = 10;
  localparam int POS_ALL       = (1 << shpm_pkg::POS_W) - 1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  shpm_pkg::cmd_t cmd_i;
  logic res_valid_o;
  shpm_pkg::res_t res_o;

  logic [shpm_pkg::HASH_W-1:0] prefix_hashes [0:TEXT_CAP];
  logic [shpm_pkg::HASH_W-1:0] mul_powers [0:TEXT_CAP];
  int unsigned                 text_len;
  shpm_pkg::res_t              awaited_answers [$];
  int                          idle_pct;
  int                          items_sent;
  int                          error_count;
  int                          stall_cycles;

  substring_hash_prefix_match_unit #(
    .MAX_LEN(TEXT_CAP)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic logic [shpm_pkg::HASH_W-1:0] span_hash(int unsigned a, int unsigned b);
    return prefix_hashes[b] - prefix_hashes[a - 1] * mul_powers[b - a + 1];
  endfunction

  function automatic int unsigned longest_prefix_match(int unsigned start_pos);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned best;
    lo   = 1;
    hi   = text_len - start_pos + 1;
    best = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (span_hash(1, mid) == span_hash(start_pos, start_pos + mid - 1)) begin
        best = mid;
        lo   = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return best;
  endfunction

  // updates the text copy and returns the answer the unit must give
  function automatic shpm_pkg::res_t match_unit_answer(shpm_pkg::cmd_t item);
    shpm_pkg::res_t ans;
    int unsigned    lp;
    int unsigned    rp;
    ans = '0;
    lp  = item.left_pos;
    rp  = item.right_pos;
    case (item.command)
      shpm_pkg::CMD_CLEAR: begin
        text_len = 0;
      end
      shpm_pkg::CMD_APPEND: begin
        if (text_len >= TEXT_CAP) begin
          ans.error_flag = 1'b1;
        end else begin
          mul_powers[text_len + 1]    = mul_powers[text_len] * shpm_pkg::HASH_MUL;
          prefix_hashes[text_len + 1] = prefix_hashes[text_len] * shpm_pkg::HASH_MUL
                                        + item.char_value;
          text_len++;
        end
      end
      shpm_pkg::CMD_HASH: begin
        if (lp == 0 || lp > rp || rp > text_len) ans.error_flag = 1'b1;
        else ans.hash_value = span_hash(lp, rp);
      end
      default: begin
        if (lp == 0 || lp > text_len) ans.error_flag = 1'b1;
        else ans.match_length = shpm_pkg::POS_W'(longest_prefix_match(lp));
      end
    endcase
    return ans;
  endfunction

  function automatic shpm_pkg::cmd_t make_item(shpm_pkg::cmd_e op, int unsigned ch,
                                               int unsigned lp, int unsigned rp);
    shpm_pkg::cmd_t item;
    item.command    = op;
    item.char_value = shpm_pkg::CHAR_W'(ch);
    item.left_pos   = shpm_pkg::POS_W'(lp);
    item.right_pos  = shpm_pkg::POS_W'(rp);
    return item;
  endfunction

  function automatic shpm_pkg::cmd_t noise_item();
    return make_item(shpm_pkg::cmd_e'($urandom_range(3)), $urandom_range(255),
                     $urandom_range(POS_ALL), $urandom_range(POS_ALL));
  endfunction

  task automatic send_item(input shpm_pkg::cmd_t item);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= item;
    do @(posedge clk_i); while (!(start && !busy));
    awaited_answers.insert(awaited_answers.size(), match_unit_answer(item));
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    shpm_pkg::res_t want;
    if (rst_ni && res_valid_o) begin
      if (awaited_answers.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: hash %h match %0d err %0b",
                   res_o.hash_value, res_o.match_length, res_o.error_flag);
      end else begin
        want = awaited_answers.pop_front();
        if (res_o.hash_value !== want.hash_value ||
            res_o.match_length !== want.match_length ||
            res_o.error_flag !== want.error_flag) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: exp hash %h match %0d err %0b, got hash %h match %0d err %0b",
                     want.hash_value, want.match_length, want.error_flag,
                     res_o.hash_value, res_o.match_length, res_o.error_flag);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[substring_hash_prefix_match_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_directed();
    idle_pct = 0;
    send_item(make_item(shpm_pkg::CMD_CLEAR, 8'hFF, POS_ALL, POS_ALL));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 1, 1));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 1, 0));
    send_item(make_item(shpm_pkg::CMD_APPEND, 8'h00, 0, 0));
    send_item(make_item(shpm_pkg::CMD_APPEND, 8'hFF, POS_ALL, POS_ALL));
    send_item(make_item(shpm_pkg::CMD_APPEND, 8'h00, 0, 0));
    send_item(make_item(shpm_pkg::CMD_APPEND, 8'hFF, 0, 0));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 1, 4));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 3, 4));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 2, 2));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 0, 2));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 3, 2));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 1, 5));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, POS_ALL, POS_ALL));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 1, 0));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 3, 0));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 4, POS_ALL));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 2, 0));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 0, 0));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 5, 0));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, POS_ALL, 0));
    send_item(make_item(shpm_pkg::CMD_CLEAR, 0, 0, 0));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 1, 1));
    wait_drained();
  endtask

  // fills the whole store with a periodic text, then overflows it
  task automatic test_full_store();
    logic [7:0] motif [5];
    idle_pct = 0;
    foreach (motif[i]) motif[i] = 8'($urandom_range(255));
    send_item(make_item(shpm_pkg::CMD_CLEAR, 0, 0, 0));
    for (int i = 0; i < TEXT_CAP; i++)
      send_item(make_item(shpm_pkg::CMD_APPEND, motif[i % 5], 0, 0));
    send_item(make_item(shpm_pkg::CMD_APPEND, 8'hA5, 0, 0));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 1, TEXT_CAP));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, TEXT_CAP, TEXT_CAP));
    send_item(make_item(shpm_pkg::CMD_HASH, 0, 1, TEXT_CAP + 1));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 1, 0));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 6, 0));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, 2, 0));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, TEXT_CAP, 0));
    send_item(make_item(shpm_pkg::CMD_MATCH, 0, TEXT_CAP + 1, 0));
    wait_drained();
  endtask

  // rounds of a clear (in most rounds), a mostly periodic text and queries mostly inside it
  task automatic test_random_traffic(input int pct, input int item_count);
    logic [7:0]  motif [6];
    int          first_item;
    int          period;
    int          text_size;
    int          queries;
    int          alphabet;
    int unsigned lp;
    int unsigned pick;
    idle_pct   = pct;
    first_item = items_sent;
    while (items_sent - first_item < item_count) begin
      if ($urandom_range(99) < 85) send_item(make_item(shpm_pkg::CMD_CLEAR, 0, 0, 0));
      period    = $urandom_range(1, 6);
      alphabet  = ($urandom_range(99) < 80) ? 2 : 255;
      text_size = ($urandom_range(99) < 90) ? $urandom_range(1, 40) : $urandom_range(41, 400);
      foreach (motif[i]) motif[i] = 8'($urandom_range(alphabet));
      for (int i = 0; i < text_size; i++) begin
        if ($urandom_range(99) < 8)
          send_item(make_item(shpm_pkg::CMD_APPEND, $urandom_range(255), 0, 0));
        else
          send_item(make_item(shpm_pkg::CMD_APPEND, motif[i % period], 0, 0));
      end
      queries = $urandom_range(1, 12);
      for (int q = 0; q < queries; q++) begin
        pick = $urandom_range(99);
        if (text_len == 0 || pick >= 85) begin
          send_item(noise_item());
        end else if (pick < 45) begin
          lp = $urandom_range(1, text_len);
          send_item(make_item(shpm_pkg::CMD_HASH, $urandom_range(255), lp,
                              $urandom_range(lp, text_len)));
        end else begin
          lp = ($urandom_range(99) < 30) ? 1 + period * $urandom_range(0, 3)
                                         : $urandom_range(1, text_len);
          send_item(make_item(shpm_pkg::CMD_MATCH, $urandom_range(255), lp,
                              $urandom_range(POS_ALL)));
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    cmd_i            <= '0;
    text_len         = 0;
    prefix_hashes[0] = '0;
    mul_powers[0]    = 64'd1;
    idle_pct         = 0;
    items_sent       = 0;
    error_count      = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_store();
    test_random_traffic(0, 620);
    test_random_traffic(66, 620);
    test_random_traffic(23, 610);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && awaited_answers.size() == 0) begin
      $display("[substring_hash_prefix_match_unit] OK");
    end else begin
      $display("[substring_hash_prefix_match_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/shpm_pkg.sv
rtl/core/shpm_ram.sv
rtl/core/shpm_mul.sv
rtl/core/substring_hash_prefix_match_unit.sv
test/substring_hash_prefix_match_unit_tb.sv
